// ----- rtl/urkf_pkg.sv -----
// ----------------------------------------------------------------------------
// urkf_pkg: shared types and constants for the ultrasonic range filter
// Fixed-point formats, register map, sequencer states and unit request types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urkf_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned EST_W      = 25;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned VAR_W      = 32;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 5;
  localparam int unsigned TDATA_IN_W = 16;
  localparam int unsigned TDATA_OUT_W = 32;

  localparam logic [PULSE_W-1:0] TIMEOUT_US = 16'd25000;

  // round(0.01715 * 2^FRAC_BITS)
  localparam int unsigned CM_PER_US_INT = ((1715 << FRAC_BITS) + 50000) / 100000;
  localparam int unsigned CM_PER_US_W   = 11;
  localparam logic [CM_PER_US_W-1:0] CM_PER_US = CM_PER_US_W'(CM_PER_US_INT);

  localparam logic [VAR_W-1:0] ONE_FX  = VAR_W'(1) << FRAC_BITS;
  localparam logic [VAR_W-1:0] HALF_FX = VAR_W'(1) << (FRAC_BITS - 1);
  localparam logic [CFG_W-1:0] HALF_FX_CFG = CFG_W'(1) << (FRAC_BITS - 1);

  localparam logic [EST_W-1:0] MIN_CM_FX     = EST_W'(2) << FRAC_BITS;
  localparam logic [EST_W-1:0] MAX_CM_FX     = EST_W'(400) << FRAC_BITS;
  localparam logic [EST_W-1:0] BIG_INNOV_FX  = EST_W'(10) << FRAC_BITS;
  localparam logic [EST_W-1:0] HUGE_INNOV_FX = EST_W'(50) << FRAC_BITS;

  // register reset values
  localparam logic [CFG_W-1:0] RST_Q0  = 24'd65536;
  localparam logic [CFG_W-1:0] RST_R   = 24'd32768;
  localparam logic [CFG_W-1:0] RST_P0  = 24'd65536;
  localparam logic [EST_W-1:0] RST_X0  = 25'd1310720;
  localparam logic [EST_W-1:0] RST_THR = 25'd655360;

  // blend of 0.7 measurement and 0.3 estimate: (7m + 3e + 5) / 10
  localparam int unsigned BLEND_W = 29;
  localparam logic [BLEND_W-1:0] BLEND_BIAS = BLEND_W'(5);
  localparam logic [3:0]         BLEND_DIV  = 4'd10;

  // serial divider: one quotient bit per cycle
  localparam int unsigned DIV_W   = VAR_W + 2;
  localparam int unsigned DIV_N_W = BLEND_W;
  localparam int unsigned CNT_W   = 5;
  localparam logic [CNT_W-1:0] GAIN_STEPS  = CNT_W'(FRAC_BITS);
  localparam logic [CNT_W-1:0] BLEND_STEPS = CNT_W'(BLEND_W);

  // serial multiplier: one multiplier bit per cycle
  localparam int unsigned MUL_A_W = VAR_W;
  localparam int unsigned MUL_B_W = FRAC_BITS + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MUL_B_W);

  typedef enum logic [2:0] {
    REG_Q0  = 3'd0,
    REG_R   = 3'd1,
    REG_P0  = 3'd2,
    REG_X0  = 3'd3,
    REG_THR = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_VAR,
    ST_GAIN,
    ST_GAIN_WAIT,
    ST_UPDATE,
    ST_UPDATE_WAIT,
    ST_APPLY,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [CNT_W-1:0]   steps;
    logic [DIV_W-1:0]   rem0;
    logic [DIV_W-1:0]   divisor;
    logic [DIV_N_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

// ----- rtl/ultrasonic_range_kalman_filter_core.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_range_kalman_filter_core: echo pulse to filtered distance
// With no filter step a transaction passes the check and output states; a step
// adds variance, gain and update states, where the 0.7/0.3 blend replaces the
// gain update. The 16-step serial gain divide and 17-step serial multiply (or
// 29-step blend divide) dominate a step; one item is in flight at a time, so a
// new one is taken only after the last is loaded into the output register.
// Reset reloads registers to defaults and the filter state from them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_range_kalman_filter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [urkf_pkg::TDATA_IN_W-1:0]    s_axis_tdata,   // [15:0] pulse_us
  input  logic                               s_axis_tuser,   // [0] echo_seen
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [urkf_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,   // [24:0] distance_estimate
  output logic [1:0]                         m_axis_tuser,   // [0] obstacle, [1] filter_updated
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [urkf_pkg::APB_AW-1:0]        paddr,
  input  logic [urkf_pkg::APB_DW-1:0]        pwdata,
  output logic [urkf_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  localparam int unsigned EW = urkf_pkg::EST_W;
  localparam int unsigned VW = urkf_pkg::VAR_W;
  localparam int unsigned FB = urkf_pkg::FRAC_BITS;
  localparam int unsigned PULSE_W_L = urkf_pkg::PULSE_W;
  localparam int unsigned MEAS_FULL_W = PULSE_W_L + urkf_pkg::CM_PER_US_W;

  // configuration registers
  logic [urkf_pkg::CFG_W-1:0] reg_q0_q, reg_r_q, reg_p0_q;
  logic [EW-1:0]              reg_x0_q, reg_thr_q;
  logic                       reload_q;
  logic [2:0]                 cfg_idx;
  logic                       cfg_wr, cfg_hit;
  logic [urkf_pkg::CFG_W-1:0] r_eff;

  // sequencer and filter state
  urkf_pkg::state_e state_q, state_d;
  logic [EW-1:0]    est_q, est_d;
  logic [VW-1:0]    p_q, p_d;
  logic [VW-1:0]    q_q, q_d;

  // per-item working registers
  logic [EW-1:0]                meas_q;
  logic                         valid_q;
  logic                         step_q;
  logic                         meas_lt_q;
  logic                         neg_q;
  logic                         huge_q;
  logic [EW-1:0]                mag_q;
  logic [urkf_pkg::BLEND_W-1:0] blend_q;

  // output register
  logic          m_valid_q;
  logic [EW-1:0] m_est_q;
  logic          m_obst_q, m_upd_q;

  // units
  urkf_pkg::div_req_t div_req;
  urkf_pkg::mul_req_t mulp_req, muld_req;
  logic                           div_busy, mulp_busy, muld_busy;
  logic [urkf_pkg::DIV_N_W-1:0]   div_quo;
  logic [urkf_pkg::MUL_P_W-1:0]   mulp_prod, muld_prod;

  logic                 in_acc;
  logic                 out_load;
  logic [FB-1:0]        gain;
  logic [PULSE_W_L-1:0] pulse_in;

  logic [MEAS_FULL_W-1:0] meas_full;
  logic                   pulse_ok;

  // check-stage logic
  logic          chk_inrange, chk_step, chk_neg;
  logic [EW-1:0] chk_mag;
  logic [VW-1:0] q_dbl;
  logic [VW:0]   p_sum;

  // apply-stage logic
  logic [urkf_pkg::MUL_P_W-1:0] rnd;
  logic [EW-1:0]                delta;
  logic [EW:0]                  est_raw;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_idx = paddr[urkf_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && (cfg_idx <= urkf_pkg::REG_THR);
  assign r_eff   = (reg_r_q == '0) ? urkf_pkg::HALF_FX_CFG : reg_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q0_q  <= urkf_pkg::RST_Q0;
      reg_r_q   <= urkf_pkg::RST_R;
      reg_p0_q  <= urkf_pkg::RST_P0;
      reg_x0_q  <= urkf_pkg::RST_X0;
      reg_thr_q <= urkf_pkg::RST_THR;
      reload_q  <= 1'b0;
    end else begin
      reload_q <= cfg_hit;
      if (cfg_wr) begin
        unique case (cfg_idx)
          urkf_pkg::REG_Q0:  reg_q0_q  <= pwdata[urkf_pkg::CFG_W-1:0];
          urkf_pkg::REG_R:   reg_r_q   <= pwdata[urkf_pkg::CFG_W-1:0];
          urkf_pkg::REG_P0:  reg_p0_q  <= pwdata[urkf_pkg::CFG_W-1:0];
          urkf_pkg::REG_X0:  reg_x0_q  <= pwdata[EW-1:0];
          urkf_pkg::REG_THR: reg_thr_q <= pwdata[EW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (cfg_idx)
      urkf_pkg::REG_Q0:  prdata = urkf_pkg::APB_DW'(reg_q0_q);
      urkf_pkg::REG_R:   prdata = urkf_pkg::APB_DW'(reg_r_q);
      urkf_pkg::REG_P0:  prdata = urkf_pkg::APB_DW'(reg_p0_q);
      urkf_pkg::REG_X0:  prdata = urkf_pkg::APB_DW'(reg_x0_q);
      urkf_pkg::REG_THR: prdata = urkf_pkg::APB_DW'(reg_thr_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- units
  urkf_sdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  urkf_smul u_mul_var (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mulp_req),
    .busy_o (mulp_busy),
    .prod_o (mulp_prod)
  );

  urkf_smul u_mul_innov (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (muld_req),
    .busy_o (muld_busy),
    .prod_o (muld_prod)
  );

  assign gain = div_quo[FB-1:0];

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      urkf_pkg::ST_IDLE:        if (in_acc) state_d = urkf_pkg::ST_CHECK;
      urkf_pkg::ST_CHECK:       state_d = chk_step ? urkf_pkg::ST_VAR : urkf_pkg::ST_OUT;
      urkf_pkg::ST_VAR:         state_d = urkf_pkg::ST_GAIN;
      urkf_pkg::ST_GAIN:        state_d = urkf_pkg::ST_GAIN_WAIT;
      urkf_pkg::ST_GAIN_WAIT:   if (!div_busy) state_d = urkf_pkg::ST_UPDATE;
      urkf_pkg::ST_UPDATE:      state_d = urkf_pkg::ST_UPDATE_WAIT;
      urkf_pkg::ST_UPDATE_WAIT: begin
        if (!div_busy && !mulp_busy && !muld_busy) state_d = urkf_pkg::ST_APPLY;
      end
      urkf_pkg::ST_APPLY:       state_d = urkf_pkg::ST_OUT;
      urkf_pkg::ST_OUT:         if (out_load) state_d = urkf_pkg::ST_IDLE;
      default:                  state_d = urkf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    div_req       = '0;
    mulp_req      = '0;
    muld_req      = '0;
    unique case (state_q)
      urkf_pkg::ST_IDLE: s_axis_tready = !reload_q;
      urkf_pkg::ST_GAIN: begin
        // p < p + r, so the integer part of the quotient is zero
        div_req.start   = 1'b1;
        div_req.steps   = urkf_pkg::GAIN_STEPS;
        div_req.rem0    = urkf_pkg::DIV_W'(p_q);
        div_req.divisor = urkf_pkg::DIV_W'(p_q) + urkf_pkg::DIV_W'(r_eff);
      end
      urkf_pkg::ST_UPDATE: begin
        mulp_req.start = 1'b1;
        mulp_req.a     = p_q;
        mulp_req.b     = urkf_pkg::MUL_B_W'(urkf_pkg::ONE_FX) - {1'b0, gain};
        if (huge_q) begin
          div_req.start   = 1'b1;
          div_req.steps   = urkf_pkg::BLEND_STEPS;
          div_req.divisor = urkf_pkg::DIV_W'(urkf_pkg::BLEND_DIV);
          div_req.num     = blend_q;
        end else begin
          muld_req.start = 1'b1;
          muld_req.a     = urkf_pkg::MUL_A_W'(mag_q);
          muld_req.b     = {1'b0, gain};
        end
      end
      urkf_pkg::ST_OUT: out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- datapath
  assign pulse_in  = s_axis_tdata[PULSE_W_L-1:0];
  assign meas_full = MEAS_FULL_W'(pulse_in) * MEAS_FULL_W'(urkf_pkg::CM_PER_US);
  assign pulse_ok  = s_axis_tuser && (pulse_in != '0) && (pulse_in < urkf_pkg::TIMEOUT_US);

  assign chk_inrange = (meas_q >= urkf_pkg::MIN_CM_FX) && (meas_q <= urkf_pkg::MAX_CM_FX);
  assign chk_step    = valid_q && chk_inrange;
  assign chk_neg     = meas_q < est_q;
  assign chk_mag     = chk_neg ? (est_q - meas_q) : (meas_q - est_q);
  assign q_dbl       = q_q[VW-1] ? '1 : {q_q[VW-2:0], 1'b0};
  assign p_sum       = {1'b0, p_q} + {1'b0, q_q};

  assign rnd   = muld_prod + urkf_pkg::MUL_P_W'(urkf_pkg::HALF_FX);
  assign delta = rnd[FB+EW-1:FB];

  always_comb begin
    if (huge_q) begin
      est_raw = (EW+1)'(div_quo);
    end else if (neg_q) begin
      est_raw = (delta > est_q) ? '0 : {1'b0, est_q - delta};
    end else begin
      est_raw = {1'b0, est_q} + {1'b0, delta};
    end
  end

  always_comb begin
    est_d = est_q;
    p_d   = p_q;
    q_d   = q_q;
    if (reload_q) begin
      est_d = reg_x0_q;
      p_d   = (reg_p0_q == '0) ? urkf_pkg::ONE_FX : VW'(reg_p0_q);
      q_d   = (reg_q0_q == '0) ? urkf_pkg::ONE_FX : VW'(reg_q0_q);
    end else begin
      case (state_q)
        urkf_pkg::ST_CHECK: begin
          if (chk_step) q_d = (chk_mag > urkf_pkg::BIG_INNOV_FX) ? q_dbl : urkf_pkg::ONE_FX;
        end
        urkf_pkg::ST_VAR: p_d = p_sum[VW] ? '1 : p_sum[VW-1:0];
        urkf_pkg::ST_APPLY: begin
          if (est_raw < (EW+1)'(urkf_pkg::MIN_CM_FX)) begin
            est_d = urkf_pkg::MIN_CM_FX;
          end else if (est_raw > (EW+1)'(urkf_pkg::MAX_CM_FX)) begin
            est_d = urkf_pkg::MAX_CM_FX;
          end else begin
            est_d = est_raw[EW-1:0];
          end
          p_d = mulp_prod[VW+FB-1:FB];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= urkf_pkg::ST_IDLE;
      est_q     <= urkf_pkg::RST_X0;
      p_q       <= VW'(urkf_pkg::RST_P0);
      q_q       <= VW'(urkf_pkg::RST_Q0);
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      est_q   <= est_d;
      p_q     <= p_d;
      q_q     <= q_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q  <= meas_full[EW-1:0];
      valid_q <= pulse_ok;
    end
    if (state_q == urkf_pkg::ST_CHECK) begin
      step_q    <= chk_step;
      meas_lt_q <= valid_q && (meas_q < reg_thr_q);
      neg_q     <= chk_neg;
      mag_q     <= chk_mag;
      huge_q    <= chk_mag >= urkf_pkg::HUGE_INNOV_FX;
      blend_q   <= (urkf_pkg::BLEND_W'(meas_q) << 3) - urkf_pkg::BLEND_W'(meas_q)
                 + (urkf_pkg::BLEND_W'(est_q) << 1) + urkf_pkg::BLEND_W'(est_q)
                 + urkf_pkg::BLEND_BIAS;
    end
    if (out_load) begin
      m_est_q  <= est_q;
      m_obst_q <= meas_lt_q || (est_q < reg_thr_q);
      m_upd_q  <= step_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = urkf_pkg::TDATA_OUT_W'(m_est_q);
  assign m_axis_tuser  = {m_upd_q, m_obst_q};

  // ---------------------------------------------------------------- checks
  a_upd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata[EW-1:0] >= urkf_pkg::MIN_CM_FX) &&
      (m_axis_tdata[EW-1:0] <= urkf_pkg::MAX_CM_FX))
    else $error("updated estimate outside 2..400 cm");

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy && !mulp_busy && !muld_busy)
    else $error("input ready while an arithmetic unit is busy");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction accepted while one is in flight");

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

// ----- rtl/urkf_sdiv.sv -----
// ----------------------------------------------------------------------------
// urkf_sdiv: bit-serial restoring divider
// Shifts one dividend bit into the partial remainder per cycle and emits one
// quotient bit per cycle, msb first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urkf_sdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urkf_pkg::div_req_t            req_i,
  output logic                          busy_o,
  output logic [urkf_pkg::DIV_N_W-1:0]  quo_o
);

  logic                          busy_q, busy_d;
  logic [urkf_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [urkf_pkg::DIV_W-1:0]    rem_q, rem_d;
  logic [urkf_pkg::DIV_W-1:0]    div_q, div_d;
  logic [urkf_pkg::DIV_N_W-1:0]  num_q, num_d;
  logic [urkf_pkg::DIV_N_W-1:0]  quo_q, quo_d;
  logic [urkf_pkg::DIV_W:0]      trial;
  logic [urkf_pkg::DIV_W:0]      diff;
  logic                          ge;

  assign trial = {rem_q, num_q[urkf_pkg::DIV_N_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem0;
      div_d  = req_i.divisor;
      num_d  = req_i.num;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[urkf_pkg::DIV_W-1:0] : trial[urkf_pkg::DIV_W-1:0];
      num_d = {num_q[urkf_pkg::DIV_N_W-2:0], 1'b0};
      quo_d = {quo_q[urkf_pkg::DIV_N_W-2:0], ge};
      cnt_d = cnt_q - urkf_pkg::CNT_W'(1);
      if (cnt_q == urkf_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/urkf_smul.sv -----
// ----------------------------------------------------------------------------
// urkf_smul: bit-serial shift-and-add multiplier
// Consumes one multiplier bit per cycle, lsb first, adding the multiplicand
// into the upper MUL_A_W bits of a right-shifting accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urkf_smul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urkf_pkg::mul_req_t            req_i,
  output logic                          busy_o,
  output logic [urkf_pkg::MUL_P_W-1:0]  prod_o
);

  logic                          busy_q, busy_d;
  logic [urkf_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [urkf_pkg::MUL_A_W-1:0]  a_q, a_d;
  logic [urkf_pkg::MUL_B_W-1:0]  b_q, b_d;
  logic [urkf_pkg::MUL_P_W-1:0]  acc_q, acc_d;
  logic [urkf_pkg::MUL_A_W:0]    sum;

  assign sum = {1'b0, acc_q[urkf_pkg::MUL_P_W-1:urkf_pkg::MUL_B_W]}
             + {1'b0, (b_q[0] ? a_q : '0)};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = urkf_pkg::MUL_STEPS;
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = {sum, acc_q[urkf_pkg::MUL_B_W-1:1]};
      b_d   = {1'b0, b_q[urkf_pkg::MUL_B_W-1:1]};
      cnt_d = cnt_q - urkf_pkg::CNT_W'(1);
      if (cnt_q == urkf_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule
